[hw/rtl/hlf_pkg.sv]
// ----------------------------------------------------------------------------
// hlf_pkg
// Shared types, constants and helpers for the log-space forward step.
// ----------------------------------------------------------------------------
package hlf_pkg;
   localparam int NUM_STATES   = 8;
   localparam int NUM_SYMBOLS  = 16;
   localparam int NUM_CHANNELS = 4;
   localparam int VALUE_BITS   = 24;
   localparam int STATE_BITS   = 3;
   localparam int SYM_BITS     = 4;
   localparam int CH_BITS      = 2;
   localparam int QUEUE_DEPTH  = 2;

   localparam logic signed [VALUE_BITS-1:0] LZ   = {1'b1, {(VALUE_BITS-1){1'b0}}};
   localparam logic signed [VALUE_BITS-1:0] VMAX = {1'b0, {(VALUE_BITS-1){1'b1}}};

   typedef enum logic [1:0] {
      FUNC_LOAD_TRANS = 2'd0,
      FUNC_LOAD_EMIT  = 2'd1,
      FUNC_LOAD_INIT  = 2'd2,
      FUNC_OBSERVE    = 2'd3
   } func_type;

   localparam logic [0:0] CSR_STATES   = 1'd0;
   localparam logic [0:0] CSR_CHANNELS = 1'd1;

   typedef logic signed [VALUE_BITS-1:0] value_type;

   // One observation word as handed from the front part to the engine.
   typedef struct packed {
      logic                  seq_start;
      logic [SYM_BITS-1:0]   sym_0;
      logic [SYM_BITS-1:0]   sym_1;
      logic [SYM_BITS-1:0]   sym_2;
      logic [SYM_BITS-1:0]   sym_3;
   } obs_type;

   // Table write from the front part.
   typedef struct packed {
      logic                  trans_we;
      logic                  emit_we;
      logic                  init_we;
      logic [STATE_BITS-1:0] row;
      logic [SYM_BITS-1:0]   col;
      logic [CH_BITS-1:0]    ch;
      value_type             value;
   } load_type;

   function automatic logic [9:0] corr_lookup(input logic [4:0] k);
      logic [9:0] r;
      case (k)
         5'd0: r = 10'd710;  5'd1: r = 10'd590;  5'd2: r = 10'd485;  5'd3: r = 10'd396;
         5'd4: r = 10'd321;  5'd5: r = 10'd258;  5'd6: r = 10'd206;  5'd7: r = 10'd164;
         5'd8: r = 10'd130;  5'd9: r = 10'd103;  5'd10: r = 10'd81;  5'd11: r = 10'd63;
         5'd12: r = 10'd50;  5'd13: r = 10'd39;  5'd14: r = 10'd30;  5'd15: r = 10'd24;
         5'd16: r = 10'd19;  5'd17: r = 10'd15;  5'd18: r = 10'd11;  5'd19: r = 10'd9;
         5'd20: r = 10'd7;   5'd21: r = 10'd5;   5'd22: r = 10'd4;   5'd23: r = 10'd3;
         5'd24: r = 10'd3;   5'd25: r = 10'd2;   5'd26: r = 10'd2;   5'd27: r = 10'd1;
         5'd28: r = 10'd1;   5'd29: r = 10'd1;   5'd30: r = 10'd1;
         default: r = 10'd0;
      endcase
      return r;
   endfunction

   // Saturating log-domain add; log zero absorbs.
   function automatic value_type ladd(input value_type a, input value_type b);
      logic signed [VALUE_BITS:0] s;
      value_type r;
      s = {a[VALUE_BITS-1], a} + {b[VALUE_BITS-1], b};
      if (a == LZ || b == LZ) r = LZ;
      else if (s <= $signed({LZ[VALUE_BITS-1], LZ})) r = LZ;
      else if (s > $signed({1'b0, VMAX})) r = VMAX;
      else r = s[VALUE_BITS-1:0];
      return r;
   endfunction
endpackage

[hw/rtl/hlf_stream_if.sv]
// ----------------------------------------------------------------------------
// hlf_stream_if
// Valid/ready channel carrying one payload word.
// ----------------------------------------------------------------------------
interface hlf_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[hw/rtl/hlf_front.sv]
// ----------------------------------------------------------------------------
// hlf_front
// Classifies input words: loads become table writes, observations are
// pushed into a short queue toward the engine.
// ----------------------------------------------------------------------------
module hlf_front
   import hlf_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  logic [1:0]            in_func,
   input  logic [STATE_BITS-1:0] in_row,
   input  logic [SYM_BITS-1:0]   in_col,
   input  logic [CH_BITS-1:0]    in_ch,
   input  value_type             in_value,
   input  obs_type               in_obs,
   input  logic     eng_idle,
   output load_type load,
   output logic     obs_valid,
   output obs_type  obs,
   input  logic     obs_pop
);
   obs_type    q_ff [QUEUE_DEPTH];
   logic [1:0] cnt_ff, cnt_in;
   logic       rd_ff, wr_ff;
   logic       is_obs, push, load_ok;
   func_type   f;

   assign f        = func_type'(in_func);
   assign is_obs   = (f == FUNC_OBSERVE);
   // A load waits until no observation is queued or in work, so every
   // observation sees exactly the tables written before it.
   assign load_ok  = (cnt_ff == 2'd0) && eng_idle;
   assign in_ready = is_obs ? (cnt_ff != 2'(QUEUE_DEPTH)) : load_ok;
   assign push     = in_valid && in_ready && is_obs;

   always_comb begin
      load.row      = in_row;
      load.col      = in_col;
      load.ch       = in_ch;
      load.value    = in_value;
      load.trans_we = in_valid && in_ready && (f == FUNC_LOAD_TRANS) && !in_col[3];
      load.emit_we  = in_valid && in_ready && (f == FUNC_LOAD_EMIT);
      load.init_we  = in_valid && in_ready && (f == FUNC_LOAD_INIT);
   end

   assign obs_valid = (cnt_ff != 2'd0);
   assign obs       = q_ff[rd_ff];
   assign cnt_in    = cnt_ff + {1'b0, push} - {1'b0, obs_pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) wr_ff <= !wr_ff;
         if (obs_pop) rd_ff <= !rd_ff;
      end
      if (push) q_ff[wr_ff] <= in_obs;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 2'(QUEUE_DEPTH)) else $error("observation queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      obs_pop |-> obs_valid) else $error("pop from empty queue");
   a_push_counts: assert property (@(posedge clock) disable iff (reset)
      (push && !obs_pop) |=> (cnt_ff == $past(cnt_ff) + 2'd1))
      else $error("queue count lost a push");
endmodule

[hw/rtl/hlf_engine.sv]
// ----------------------------------------------------------------------------
// hlf_engine
// Sequencer that evaluates one observation: per target state it walks the
// source states through one add and log-sum-exp per cycle (or takes the init
// value at a sequence start), adds each channel emission, emits the result.
// ----------------------------------------------------------------------------
module hlf_engine
   import hlf_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic [3:0] csr_states,
   input  logic [2:0] csr_channels,
   input  load_type load,
   input  logic     obs_valid,
   input  obs_type  obs,
   output logic     obs_pop,
   output logic     idle,
   output logic     out_valid,
   input  logic     out_ready,
   output logic [STATE_BITS-1:0] out_state,
   output value_type out_alpha,
   output logic     out_last
);
   typedef enum logic [2:0] {S_IDLE, S_SUM, S_EMIT, S_OUT, S_COMMIT} state_type;

   value_type trans_mem [NUM_STATES*NUM_STATES];
   value_type emit_mem  [NUM_CHANNELS*NUM_STATES*NUM_SYMBOLS];
   value_type init_ff   [NUM_STATES];
   value_type alpha_ff  [NUM_STATES];
   value_type fresh_ff  [NUM_STATES];

   state_type st_ff;
   obs_type   ob_ff;
   logic [STATE_BITS-1:0] i_ff, j_ff;
   logic [CH_BITS-1:0]    c_ff;
   logic      jrd_ff;
   value_type acc_ff, trd_ff, erd_ff;
   logic      ex_ff;
   logic [3:0] ns;
   logic [2:0] nc;
   logic [STATE_BITS-1:0] ilast;
   logic [SYM_BITS-1:0]   sym;
   value_type term, lse, mx;
   logic signed [VALUE_BITS:0] dif, lsum;
   logic [VALUE_BITS:0] ad;

   assign ns    = (csr_states == 4'd0) ? 4'd1 : (csr_states > 4'd8 ? 4'd8 : csr_states);
   assign nc    = (csr_channels == 3'd0) ? 3'd1 : (csr_channels > 3'd4 ? 3'd4 : csr_channels);
   assign ilast = 3'(ns - 4'd1);

   always_comb begin
      case (c_ff)
         2'd0: sym = ob_ff.sym_0;
         2'd1: sym = ob_ff.sym_1;
         2'd2: sym = ob_ff.sym_2;
         default: sym = ob_ff.sym_3;
      endcase
   end

   // Pairwise log-sum-exp of the accumulator with alpha_j + trans[j][i].
   always_comb begin
      term = ladd(alpha_ff[j_ff], trd_ff);
      dif  = {acc_ff[VALUE_BITS-1], acc_ff} - {term[VALUE_BITS-1], term};
      ad   = dif[VALUE_BITS] ? VALUE_BITS'(0) - dif : dif;
      mx   = dif[VALUE_BITS] ? term : acc_ff;
      lsum = {mx[VALUE_BITS-1], mx} +
             ((ad < 8192) ? $signed({15'd0, corr_lookup(ad[12:8])}) : '0);
      if (acc_ff == LZ) lse = term;
      else if (term == LZ) lse = acc_ff;
      else if (lsum > $signed({1'b0, VMAX})) lse = VMAX;
      else lse = lsum[VALUE_BITS-1:0];
   end

   assign obs_pop   = (st_ff == S_IDLE) && obs_valid;
   assign idle      = (st_ff == S_IDLE);
   assign out_valid = (st_ff == S_OUT);
   assign out_last  = (i_ff == ilast);

   always_ff @(posedge clock) begin
      if (load.trans_we) trans_mem[{load.row, load.col[2:0]}] <= load.value;
      if (load.emit_we) emit_mem[{load.ch, load.row, load.col}] <= load.value;
      if (load.init_we) init_ff[load.row] <= load.value;
      trd_ff <= trans_mem[{(st_ff == S_SUM && jrd_ff) ? 3'(j_ff + 3'd1) : j_ff, i_ff}];
      erd_ff <= emit_mem[{c_ff, i_ff, sym}];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         for (int k = 0; k < NUM_STATES; k++) alpha_ff[k] <= LZ;
         i_ff <= '0; j_ff <= '0; c_ff <= '0; jrd_ff <= 1'b0; ex_ff <= 1'b0;
      end else begin
         case (st_ff)
            S_IDLE: if (obs_valid) begin
               ob_ff <= obs; i_ff <= '0; j_ff <= '0; c_ff <= '0;
               jrd_ff <= 1'b0; ex_ff <= 1'b0; acc_ff <= LZ;
               st_ff <= S_SUM;
            end
            S_SUM: begin
               // Without a sequence start, the first cycle of each target only primes the table read.
               if (ob_ff.seq_start) begin
                  acc_ff <= init_ff[i_ff];
                  st_ff <= S_EMIT;
               end else if (!jrd_ff) begin
                  jrd_ff <= 1'b1;
               end else begin
                  acc_ff <= lse;
                  if (j_ff == ilast) st_ff <= S_EMIT;
                  else j_ff <= j_ff + 3'd1;
               end
            end
            S_EMIT: begin
               // The emission read is registered in erd_ff and added once ex_ff is set.
               if (!ex_ff) ex_ff <= 1'b1;
               else begin
                  acc_ff <= ladd(acc_ff, erd_ff);
                  ex_ff <= 1'b0;
                  if ({1'b0, c_ff} == 3'(nc - 3'd1)) st_ff <= S_OUT;
                  else c_ff <= c_ff + 2'd1;
               end
            end
            S_OUT: if (out_ready) begin
               fresh_ff[i_ff] <= acc_ff;
               if (i_ff == ilast) st_ff <= S_COMMIT;
               else begin
                  i_ff <= i_ff + 3'd1; j_ff <= '0; c_ff <= '0;
                  jrd_ff <= 1'b0; acc_ff <= LZ; st_ff <= S_SUM;
               end
            end
            S_COMMIT: begin
               for (int k = 0; k < NUM_STATES; k++)
                  alpha_ff[k] <= (k <= int'(i_ff)) ? fresh_ff[k] : LZ;
               st_ff <= S_IDLE;
            end
            default: st_ff <= S_IDLE;
         endcase
      end
   end

   assign out_state = i_ff;
   assign out_alpha = acc_ff;

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      obs_pop |=> (st_ff == S_SUM)) else $error("pop did not start work");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (out_valid && !out_ready) |=> (out_valid && $stable(out_alpha)))
      else $error("result changed while stalled");
   a_last_commit: assert property (@(posedge clock) disable iff (reset)
      (out_valid && out_ready && out_last) |=> (st_ff == S_COMMIT))
      else $error("last result did not commit");
endmodule

[hw/rtl/hmm_log_forward_step.sv]
// ----------------------------------------------------------------------------
// hmm_log_forward_step
// One step of the log-space HMM forward recursion, Q13.10 fixed point.
// ----------------------------------------------------------------------------
// Load words are accepted only while no observation is queued or in work, and
// write the tables in the cycle they are accepted. The work on an observation
// is paced by the single add and log-sum-exp unit that the sequencer steps
// through once per source state, the registered table reads and a read then
// an add per emission; sequence starts skip the sum. Two observations may wait
// in the queue while one is worked on.
module hmm_log_forward_step
   import hlf_pkg::*;
(
   input  logic clock,
   input  logic reset,
   hlf_stream_if.sink   req,
   hlf_stream_if.source rsp,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [3:0]  csr_wdata
);
   logic [3:0] states_ff;
   logic [2:0] chans_ff;
   load_type   load;
   logic       obs_valid, obs_pop, eng_idle;
   obs_type    obs, in_obs;

   always_ff @(posedge clock) begin
      if (reset) begin
         states_ff <= 4'd8;
         chans_ff  <= 3'd1;
      end else if (csr_we) begin
         if (csr_index == CSR_STATES) states_ff <= csr_wdata;
         else if (csr_index == CSR_CHANNELS) chans_ff <= csr_wdata[2:0];
      end
   end

   always_comb begin
      in_obs.seq_start = req.payload.seq_start;
      in_obs.sym_0 = req.payload.sym_0;
      in_obs.sym_1 = req.payload.sym_1;
      in_obs.sym_2 = req.payload.sym_2;
      in_obs.sym_3 = req.payload.sym_3;
   end

   hlf_front u_front (
      .clock, .reset,
      .in_valid(req.valid), .in_ready(req.ready),
      .in_func(req.payload.func), .in_row(req.payload.row_index),
      .in_col(req.payload.col_index), .in_ch(req.payload.channel_index),
      .in_value(req.payload.table_value), .in_obs(in_obs),
      .eng_idle(eng_idle),
      .load(load), .obs_valid(obs_valid), .obs(obs), .obs_pop(obs_pop)
   );

   hlf_engine u_engine (
      .clock, .reset,
      .csr_states(states_ff), .csr_channels(chans_ff),
      .load(load), .obs_valid(obs_valid), .obs(obs), .obs_pop(obs_pop),
      .idle(eng_idle),
      .out_valid(rsp.valid), .out_ready(rsp.ready),
      .out_state(rsp.payload.state_index), .out_alpha(rsp.payload.log_alpha),
      .out_last(rsp.payload.last)
   );
endmodule
